@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off during reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Check an implication on every rising clock edge, held off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/cpf_pkg.sv @@
// Shared types and constants of the 3x3 pixel filter.
// No dependencies.
package cpf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int COEFF_BITS_DEF = 16;
  localparam int MAX_HEIGHT     = 1024;
  localparam int PIX_MAX        = 255;
  localparam int CFG_W          = 48;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

@@ sv/conv3x3_pixel_filter_top.sv @@
// Top level of the 3x3 convolution filter over one 8-bit plane in raster order.
// Depends on cpf_pkg for state codes, register indexes and size defaults.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | pixel_sample_i, frame_start_i
//  out     | source    | out_valid_o / out_stall_i | filtered_value_o, out_row_o,
//          |           |                           | out_column_o, frame_done_o
//  cfg     | sink      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One sample at a time: accept, read both line stores, write back and shift the
// window, then nine multiply-accumulate steps on a single multiplier.
// A sample with no result skips the multiply-accumulate; the divide, one quotient
// bit per cycle, runs only when the divisor is not 0 or 1.
// The result sits in an output register, so a stalled output only holds the next
// sample's finish step; new samples are still taken while a result waits.
// Reset clears control, position counters, window and config; the line stores are not cleared.
module conv3x3_pixel_filter_top #(
  parameter int MAX_WIDTH  = cpf_pkg::MAX_WIDTH_DEF,
  parameter int COEFF_BITS = cpf_pkg::COEFF_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     pixel_sample_i,
  input  logic                           frame_start_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     filtered_value_o,
  output logic [9:0]                     out_row_o,
  output logic [9:0]                     out_column_o,
  output logic                           frame_done_o
);

  localparam int IW  = $clog2(MAX_WIDTH);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int SW  = COEFF_BITS + 13;
  localparam int DCW = $clog2(SW + 1);
  localparam int PW  = COEFF_BITS + 9;

  // configuration registers
  logic [cpf_pkg::CFG_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
  logic [7:0]                div_q;
  logic [10:0]               width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_top_q <= '0;
      coef_mid_q <= cpf_pkg::CFG_W'(1);
      coef_bot_q <= '0;
      div_q      <= 8'd1;
      width_q    <= 11'd1024;
      height_q   <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpf_pkg::CFG_COEFF_TOP: coef_top_q <= cfg_data_i;
        cpf_pkg::CFG_COEFF_MID: coef_mid_q <= cfg_data_i;
        cpf_pkg::CFG_COEFF_BOT: coef_bot_q <= cfg_data_i;
        cpf_pkg::CFG_DIVISOR:   div_q      <= cfg_data_i[7:0];
        cpf_pkg::CFG_WIDTH:     width_q    <= cfg_data_i[10:0];
        cpf_pkg::CFG_HEIGHT:    height_q   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // effective plane size: clamp to 3 .. maximum
  logic [WW-1:0] w_eff;
  logic [10:0]   h_eff;

  always_comb begin
    if (WW'(width_q) < WW'(3))              w_eff = WW'(3);
    else if (WW'(width_q) > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                                    w_eff = WW'(width_q);
    if (height_q < 11'd3)                                h_eff = 11'd3;
    else if (height_q > 11'(cpf_pkg::MAX_HEIGHT))        h_eff = 11'(cpf_pkg::MAX_HEIGHT);
    else                                                 h_eff = height_q;
  end

  // sequencer
  cpf_pkg::state_e st_q, st_d;
  logic [3:0]      k_q;
  logic [DCW-1:0]  dcnt_q;
  logic            in_xfer, out_free, hit, div_skip;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      cpf_pkg::ST_IDLE: if (in_valid_i) st_d = cpf_pkg::ST_LOAD;
      cpf_pkg::ST_LOAD: st_d = hit ? cpf_pkg::ST_MAC : cpf_pkg::ST_IDLE;
      cpf_pkg::ST_MAC:  if (k_q == 4'd8) st_d = div_skip ? cpf_pkg::ST_DONE : cpf_pkg::ST_DIV;
      cpf_pkg::ST_DIV:  if (dcnt_q == DCW'(SW - 1)) st_d = cpf_pkg::ST_DONE;
      cpf_pkg::ST_DONE: if (out_free) st_d = cpf_pkg::ST_IDLE;
      default:          st_d = cpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (st_q != cpf_pkg::ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= cpf_pkg::ST_IDLE;
    else         st_q <= st_d;
  end

  // position counters and the captured sample
  logic [9:0]    row_q, r_cur, r_item_q;
  logic [IW-1:0] col_q, c_cur, c_item_q;
  logic [7:0]    pix_q;

  assign r_cur = frame_start_i ? '0 : row_q;
  assign c_cur = frame_start_i ? '0 : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_xfer) begin
      // wrap the column at the row end, the row at the plane end
      if (WW'(c_cur) + WW'(1) >= w_eff) begin
        col_q <= '0;
        row_q <= (11'(r_cur) + 11'd1 >= h_eff) ? '0 : r_cur + 10'd1;
      end else begin
        col_q <= c_cur + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pix_q    <= pixel_sample_i;
      r_item_q <= r_cur;
      c_item_q <= c_cur;
    end
  end

  // line stores: read on transfer, write back in the next cycle (ST_LOAD)
  logic [7:0] ls_a [MAX_WIDTH];
  logic [7:0] ls_b [MAX_WIDTH];
  logic [7:0] up1_q, up2_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      up1_q <= ls_a[c_cur];
      up2_q <= ls_b[c_cur];
    end
    if (st_q == cpf_pkg::ST_LOAD) begin
      ls_a[c_item_q] <= pix_q;
      ls_b[c_item_q] <= up1_q;
    end
  end

  // 3x3 window, index row*3+col, top-left first
  logic [7:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (st_q == cpf_pkg::ST_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= up2_q;
      win_q[5] <= up1_q;
      win_q[8] <= pix_q;
    end
  end

  assign hit = (r_item_q >= 10'd2) && (c_item_q >= IW'(2)) &&
               (11'(r_item_q) < h_eff) && (WW'(c_item_q) < w_eff);

  // result position, latched while the window shifts
  logic [9:0] orow_q, ocol_q;
  logic       odone_q;

  always_ff @(posedge clk_i) begin
    if (st_q == cpf_pkg::ST_LOAD) begin
      orow_q  <= r_item_q - 10'd1;
      ocol_q  <= 10'(c_item_q - IW'(1));
      odone_q <= (11'(r_item_q) == h_eff - 11'd1) && (WW'(c_item_q) == w_eff - WW'(1));
    end
  end

  // multiply-accumulate, one tap per cycle
  logic [cpf_pkg::CFG_W-1:0]   row_reg;
  logic [1:0]                  slot;
  logic signed [COEFF_BITS-1:0] coef;
  logic signed [PW-1:0]         prod;
  logic signed [SW-1:0]         acc_q, sum_nx;

  always_comb begin
    if (k_q < 4'd3) begin
      row_reg = coef_top_q;
      slot    = 2'(k_q);
    end else if (k_q < 4'd6) begin
      row_reg = coef_mid_q;
      slot    = 2'(k_q - 4'd3);
    end else begin
      row_reg = coef_bot_q;
      slot    = 2'(k_q - 4'd6);
    end
    coef   = $signed(row_reg[slot*COEFF_BITS +: COEFF_BITS]);
    prod   = $signed({1'b0, win_q[k_q]}) * coef;
    sum_nx = acc_q + SW'(prod);
  end

  // divisor magnitude and skip rule
  logic signed [7:0] dv;
  logic [7:0]        dvm;

  assign dv       = $signed(div_q);
  assign div_skip = (div_q == 8'd0) || (div_q == 8'd1);
  assign dvm      = dv[7] ? 8'(-dv) : div_q;

  // restoring divide of the magnitude, one quotient bit per cycle
  logic [SW-1:0] quo_q;
  logic [7:0]    rem_q;
  logic          neg_q;
  logic [8:0]    trial;
  logic          ge;

  assign trial = {rem_q, quo_q[SW-1]};
  assign ge    = (trial >= {1'b0, dvm});

  always_ff @(posedge clk_i) begin
    case (st_q)
      cpf_pkg::ST_LOAD: begin
        acc_q <= '0;
        k_q   <= '0;
      end
      cpf_pkg::ST_MAC: begin
        acc_q <= sum_nx;
        k_q   <= k_q + 4'd1;
        if (k_q == 4'd8) begin
          quo_q  <= sum_nx[SW-1] ? SW'(-sum_nx) : SW'(sum_nx);
          neg_q  <= sum_nx[SW-1] ^ (!div_skip && dv[7]);
          rem_q  <= '0;
          dcnt_q <= '0;
        end
      end
      cpf_pkg::ST_DIV: begin
        rem_q  <= ge ? 8'(trial - {1'b0, dvm}) : trial[7:0];
        quo_q  <= {quo_q[SW-2:0], ge};
        dcnt_q <= dcnt_q + DCW'(1);
      end
      default: ;
    endcase
  end

  // clamp: any negative quotient gives 0, large ones saturate
  logic [7:0] clamped;

  assign clamped = neg_q ? 8'd0 :
                   (quo_q > SW'(cpf_pkg::PIX_MAX)) ? 8'(cpf_pkg::PIX_MAX) : quo_q[7:0];

  // output register
  logic       ovalid_q;
  logic [7:0] oval_q;
  logic [9:0] oqrow_q, oqcol_q;
  logic       oqdone_q;
  logic       load_out;

  assign load_out = (st_q == cpf_pkg::ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          ovalid_q <= 1'b0;
    else if (load_out)    ovalid_q <= 1'b1;
    else if (!out_stall_i) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      oval_q   <= clamped;
      oqrow_q  <= orow_q;
      oqcol_q  <= ocol_q;
      oqdone_q <= odone_q;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign filtered_value_o = oval_q;
  assign out_row_o        = oqrow_q;
  assign out_column_o     = oqcol_q;
  assign frame_done_o     = oqdone_q;

endmodule

@@ sv/cpf_checker.sv @@
// Port-level checks of the 3x3 pixel filter, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cpf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] filtered_value_o,
  input logic [9:0] out_row_o,
  input logic [9:0] out_column_o,
  input logic       frame_done_o
);

  // a held result keeps its payload
  `ASSERT_CLK(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(filtered_value_o) && $stable(out_row_o) && $stable(out_column_o) && $stable(frame_done_o)))

  // one sample at a time: a transfer closes the input for the next cycle
  `ASSERT_IMPL(a_in_one, in_valid_i && !in_stall_o, ##1 in_stall_o)

  // results only for interior pixels
  `ASSERT_IMPL(a_interior, out_valid_o, out_row_o != 10'd0 && out_column_o != 10'd0)

endmodule

bind conv3x3_pixel_filter_top cpf_checker u_cpf_checker (.*);
